// ===== hw/rtl/nbe_pkg.sv =====
package nbe_pkg;

   localparam int RunChars = 4;
   localparam int QueueDepth = 2;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ESC       = 8'h1B;
   localparam logic [7:0] CHAR_DEL       = 8'h7F;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_FORMFEED  = 8'h0C;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CARET     = 8'h5E;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_UPPER_E   = 8'h45;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_AT        = 8'h40;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   localparam logic ACTION_DATA = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   // One rendered run: up to four characters, emitted from index 0 to last_idx.
   typedef struct packed {
      logic [RunChars-1:0][7:0] chars;
      logic [1:0]               last_idx;
   } nbe_run_type;

   typedef struct packed {
      logic push;
      logic line_closed;
   } nbe_front_status_type;

   typedef struct packed {
      logic push_ready;
      logic pop_valid;
      logic pop;
   } nbe_queue_status_type;

   function automatic nbe_run_type nbe_classify(logic action, logic [7:0] c);
      nbe_run_type r;
      r.chars    = '0;
      r.last_idx = 2'd0;
      if (action == ACTION_END) begin
         r.chars[0] = CHAR_NEWLINE;
      end else begin
         case (c)
            CHAR_ESC: begin
               r.chars[0] = CHAR_NEWLINE;
               r.chars[1] = CHAR_BACKSLASH;
               r.chars[2] = CHAR_UPPER_E;
               r.last_idx = 2'd2;
            end
            CHAR_NEWLINE: begin
               r.chars[0] = CHAR_NEWLINE;
               r.chars[1] = CHAR_BACKSLASH;
               r.chars[2] = CHAR_LOWER_N;
               r.last_idx = 2'd2;
            end
            CHAR_BACKSPACE: begin
               r.chars[0] = CHAR_BACKSLASH;
               r.chars[1] = CHAR_LOWER_B;
               r.last_idx = 2'd1;
            end
            CHAR_FORMFEED: begin
               r.chars[0] = CHAR_BACKSLASH;
               r.chars[1] = CHAR_LOWER_F;
               r.last_idx = 2'd1;
            end
            CHAR_RETURN: begin
               r.chars[0] = CHAR_BACKSLASH;
               r.chars[1] = CHAR_LOWER_R;
               r.last_idx = 2'd1;
            end
            CHAR_TAB: begin
               r.chars[0] = CHAR_BACKSLASH;
               r.chars[1] = CHAR_LOWER_T;
               r.last_idx = 2'd1;
            end
            CHAR_CARET: begin
               r.chars[0] = CHAR_BACKSLASH;
               r.chars[1] = CHAR_CARET;
               r.last_idx = 2'd1;
            end
            CHAR_DEL: begin
               r.chars[0] = CHAR_BACKSLASH;
               r.chars[1] = CHAR_QUESTION;
               r.last_idx = 2'd1;
            end
            default: begin
               if (c[7]) begin
                  r.chars[0] = CHAR_BACKSLASH;
                  r.chars[1] = CHAR_ZERO | {6'd0, c[7:6]};
                  r.chars[2] = CHAR_ZERO | {5'd0, c[5:3]};
                  r.chars[3] = CHAR_ZERO | {5'd0, c[2:0]};
                  r.last_idx = 2'd3;
               end else if (c < CHAR_SPACE) begin
                  r.chars[0] = CHAR_CARET;
                  r.chars[1] = c | CHAR_AT;
                  r.last_idx = 2'd1;
               end else begin
                  r.chars[0] = c;
               end
            end
         endcase
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/nbe_front.sv =====
module nbe_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic [7:0]                   req_data_byte,
   input  logic                         queue_ready,
   output nbe_pkg::nbe_run_type         run,
   output nbe_pkg::nbe_front_status_type status
);

   logic line_closed_ff;
   logic line_closed_in;
   logic accept;

   assign req_ready = queue_ready;
   assign accept    = req_valid && queue_ready;
   assign run       = nbe_pkg::nbe_classify(req_action, req_data_byte);

   // End of stream on a closed line renders nothing: drop it here.
   assign status.push = accept &&
      ((req_action == nbe_pkg::ACTION_DATA) || !line_closed_ff);
   assign status.line_closed = line_closed_ff;

   always_comb begin
      line_closed_in = line_closed_ff;
      if (accept) begin
         if (req_action == nbe_pkg::ACTION_END) begin
            line_closed_in = 1'b1;
         end else begin
            line_closed_in = (req_data_byte == nbe_pkg::CHAR_ESC) ||
                             (req_data_byte == nbe_pkg::CHAR_NEWLINE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_closed_ff <= 1'b1;
      end else begin
         line_closed_ff <= line_closed_in;
      end
   end

endmodule

// ===== hw/rtl/nbe_queue.sv =====
module nbe_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  nbe_pkg::nbe_run_type          push_run,
   input  logic                          pop,
   output nbe_pkg::nbe_run_type          head_run,
   output nbe_pkg::nbe_queue_status_type status
);

   localparam int CountBits = $clog2(nbe_pkg::QueueDepth + 1);

   nbe_pkg::nbe_run_type entry_ff [nbe_pkg::QueueDepth];
   nbe_pkg::nbe_run_type entry_in [nbe_pkg::QueueDepth];
   logic [CountBits-1:0] count_ff;
   logic [CountBits-1:0] count_in;

   assign head_run          = entry_ff[0];
   assign status.push_ready = count_ff != CountBits'(nbe_pkg::QueueDepth);
   assign status.pop_valid  = count_ff != '0;
   assign status.pop        = pop;

   // Shift form: entry 0 is the head; a pop advances every entry by one.
   always_comb begin
      logic [CountBits-1:0] fill;
      fill = count_ff;
      for (int i = 0; i < nbe_pkg::QueueDepth; i++) begin
         entry_in[i] = entry_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < nbe_pkg::QueueDepth - 1; i++) begin
            entry_in[i] = entry_ff[i + 1];
         end
         fill = count_ff - 1'b1;
      end
      if (push) begin
         for (int i = 0; i < nbe_pkg::QueueDepth; i++) begin
            if (fill == CountBits'(i)) begin
               entry_in[i] = push_run;
            end
         end
      end
      count_in = count_ff + CountBits'(push) - CountBits'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < nbe_pkg::QueueDepth; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/nbe_back.sv =====
module nbe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_valid,
   input  nbe_pkg::nbe_run_type queue_run,
   output logic                 queue_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_char,
   output logic                 rsp_end_of_run
);

   nbe_pkg::nbe_run_type run_ff;
   nbe_pkg::nbe_run_type run_in;
   logic [1:0]           idx_ff;
   logic [1:0]           idx_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic                 last_char;
   logic                 rsp_accept;

   assign last_char      = idx_ff == run_ff.last_idx;
   assign rsp_accept     = busy_ff && rsp_ready;
   assign rsp_valid      = busy_ff;
   assign rsp_out_char   = run_ff.chars[idx_ff];
   assign rsp_end_of_run = last_char;

   // Load the next run as the last character of this one leaves.
   assign queue_pop = queue_valid && (!busy_ff || (rsp_accept && last_char));

   always_comb begin
      run_in  = run_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (queue_pop) begin
         run_in  = queue_run;
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end else if (rsp_accept) begin
         if (last_char) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      idx_ff <= idx_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== hw/rtl/nonprinting_byte_escaper_top.sv =====
// Nonprinting byte escaper: renders a byte stream as visible ASCII.
// Input channel req_: one item is a data byte (req_action low) or an end
// of stream mark (req_action high, req_data_byte ignored).
// Result channel rsp_: one item is one character; rsp_end_of_run marks the
// last character caused by an input item. A data byte gives 1 to 4
// characters; end of stream gives one newline if the line is open, else none.
// The first character of an item is offered on rsp_ once the item has
// passed the run queue register and then the back end's run register.
// Throughput: one character per cycle while rsp_ready is high, set by the
// character serialiser in the back end. A two-entry run queue lets the
// front accept new items while the back end is still sending, so the
// input stalls only when it is full.
// When the receiver holds rsp_ready low, the current character holds,
// the queue fills and req_ready then drops.
// Reset (synchronous, active high) empties the queue, drops any partial
// run and marks the line as closed.
module nonprinting_byte_escaper_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_end_of_run
);

   nbe_pkg::nbe_run_type          front_run;
   nbe_pkg::nbe_run_type          head_run;
   nbe_pkg::nbe_front_status_type front_status;
   nbe_pkg::nbe_queue_status_type queue_status;
   logic                          queue_pop;

   // Front: classify each byte into a run and track the line state.
   nbe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .queue_ready   (queue_status.push_ready),
      .run           (front_run),
      .status        (front_status)
   );

   // Queue: decouple classification from character output.
   nbe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_status.push),
      .push_run (front_run),
      .pop      (queue_pop),
      .head_run (head_run),
      .status   (queue_status)
   );

   // Back: send the run one character per cycle while rsp_ready is high.
   nbe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_valid    (queue_status.pop_valid),
      .queue_run      (head_run),
      .queue_pop      (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_end_of_run (rsp_end_of_run)
   );

   // Never pop an empty queue nor push into a full one.
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      queue_status.pop |-> queue_status.pop_valid)
      else $error("run queue popped while empty");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      front_status.push |-> queue_status.push_ready)
      else $error("run queue pushed while full");

   // End of stream always leaves the line closed.
   a_end_closes_line: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == nbe_pkg::ACTION_END)
      |=> front_status.line_closed)
      else $error("line left open after end of stream");

   // End of stream on an open line always queues its closing newline.
   a_eos_open_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == nbe_pkg::ACTION_END &&
       !front_status.line_closed) |-> front_status.push)
      else $error("closing newline dropped");

endmodule
